### src/video_chip_port_interface_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the video chip host port
// Shared same-cycle and next-cycle implication checks with a disable on reset.
// ----------------------------------------------------------------------------
`ifndef VIDEO_CHIP_PORT_INTERFACE_MACROS_SVH
`define VIDEO_CHIP_PORT_INTERFACE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VCPI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("host port check failed");

// Consequent must hold in the cycle after the antecedent.
`define VCPI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("host port check failed");

`endif

### src/vcpi_pkg.sv
// ----------------------------------------------------------------------------
// vcpi_pkg
// Types, codes and constants shared by the video chip host port modules.
// ----------------------------------------------------------------------------
package vcpi_pkg;

   localparam int ADDR_W    = 14;
   localparam int LATCH_W   = 16;
   localparam int BYTE_W    = 8;
   localparam int OP_W      = 2;
   localparam int MODE_W    = 4;
   localparam int REG_IDX_W = 4;
   localparam int CSR_IDX_W = 1;

   localparam logic [ADDR_W-1:0] ADDR_MASK         = 14'h3fff;
   localparam logic [BYTE_W-1:0] SATTR_MASK        = 8'h7e;
   localparam logic [ADDR_W-1:0] NAME_FIXED_MASK   = 14'h3800;
   localparam logic [ADDR_W-1:0] PATTERN_HALF_MASK = 14'h2000;
   localparam logic [LATCH_W-1:0] LATCH_HI_MASK    = 16'h0f00;
   localparam logic [LATCH_W-1:0] LATCH_LO_MASK    = 16'h00ff;

   localparam logic [ADDR_W-1:0] NAME_MASK_RESET    = 14'h3c00;
   localparam logic [ADDR_W-1:0] PATTERN_MASK_RESET = 14'h3800;

   // host port operations
   typedef enum logic [OP_W-1:0] {
      OP_CTRL   = 2'd0,
      OP_DWRITE = 2'd1,
      OP_DREAD  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // access codes held in the top two latch bits
   typedef enum logic [1:0] {
      CODE_VREAD  = 2'd0,
      CODE_VWRITE = 2'd1,
      CODE_REG    = 2'd2,
      CODE_COLOR  = 2'd3
   } code_type;

   // video register numbers
   localparam logic [REG_IDX_W-1:0] REG_MODE1     = 4'd0;
   localparam logic [REG_IDX_W-1:0] REG_MODE2     = 4'd1;
   localparam logic [REG_IDX_W-1:0] REG_NAME      = 4'd2;
   localparam logic [REG_IDX_W-1:0] REG_COLOR     = 4'd3;
   localparam logic [REG_IDX_W-1:0] REG_PATTERN   = 4'd4;
   localparam logic [REG_IDX_W-1:0] REG_SATTR     = 4'd5;
   localparam logic [REG_IDX_W-1:0] REG_SPAT      = 4'd6;
   localparam logic [REG_IDX_W-1:0] REG_LAST_DEF  = 4'd10;

   // decoded mode codes
   localparam logic [MODE_W-1:0] MODE_TEXT_A = 4'd9;
   localparam logic [MODE_W-1:0] MODE_TEXT_B = 4'd13;
   localparam logic [MODE_W-1:0] MODE_TEXT   = 4'd1;
   localparam logic [MODE_W-1:0] MODE_G2     = 4'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NAME_MASK    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_MASK = 1'd1;

   typedef enum logic {
      ST_IDLE,
      ST_FETCH
   } state_type;

   // register write command from the sequencer
   typedef struct packed {
      logic                 valid;
      logic [REG_IDX_W-1:0] index;
      logic [LATCH_W-1:0]   latch;
   } reg_cmd_type;

   // table base addresses
   typedef struct packed {
      logic [ADDR_W-1:0] name;
      logic [ADDR_W-1:0] color;
      logic [ADDR_W-1:0] pattern;
      logic [ADDR_W-1:0] sprite_attr;
      logic [ADDR_W-1:0] sprite_pattern;
   } base_set_type;

   // mode bits gathered from the two mode registers; text modes fold to one
   function automatic logic [MODE_W-1:0] decode_mode(input logic [BYTE_W-1:0] m1,
                                                     input logic [BYTE_W-1:0] m2);
      logic [MODE_W-1:0] vm;
      vm = {m1[2], m2[3], m1[1], m2[4]};
      if (vm == MODE_TEXT_A || vm == MODE_TEXT_B) begin
         vm = MODE_TEXT;
      end
      return vm;
   endfunction

endpackage

### src/vcpi_interfaces.sv
// ----------------------------------------------------------------------------
// Host port channel interfaces
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface vcpi_req_if;
   import vcpi_pkg::*;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [BYTE_W-1:0] data_byte;
   modport source (output valid, output opcode, output data_byte, input ready);
   modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface vcpi_rsp_if;
   import vcpi_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [BYTE_W-1:0]    read_data;
   logic [MODE_W-1:0]    video_mode;
   logic [ADDR_W-1:0]    name_base;
   logic [ADDR_W-1:0]    color_base;
   logic [ADDR_W-1:0]    pattern_base;
   logic [ADDR_W-1:0]    sprite_attr_base;
   logic [ADDR_W-1:0]    sprite_pattern_base;
   logic                 reg_write_valid;
   logic [REG_IDX_W-1:0] reg_write_index;
   logic [BYTE_W-1:0]    reg_write_value;
   logic                 undefined_reg;
   modport source (output valid, output read_data, output video_mode, output name_base,
                   output color_base, output pattern_base, output sprite_attr_base,
                   output sprite_pattern_base, output reg_write_valid,
                   output reg_write_index, output reg_write_value, output undefined_reg,
                   input ready);
   modport sink   (input valid, input read_data, input video_mode, input name_base,
                   input color_base, input pattern_base, input sprite_attr_base,
                   input sprite_pattern_base, input reg_write_valid,
                   input reg_write_index, input reg_write_value, input undefined_reg,
                   output ready);
endinterface

interface vcpi_csr_if;
   import vcpi_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [ADDR_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### src/vcpi_ram.sv
// ----------------------------------------------------------------------------
// vcpi_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module vcpi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/vcpi_regs.sv
// ----------------------------------------------------------------------------
// vcpi_regs
// Mode registers and table base decode, written on completed register pairs.
// ----------------------------------------------------------------------------
module vcpi_regs (
   input  logic                       clock,
   input  logic                       reset,
   input  vcpi_pkg::reg_cmd_type      cmd,
   input  logic [vcpi_pkg::ADDR_W-1:0] name_mask,
   input  logic [vcpi_pkg::ADDR_W-1:0] pattern_mask,
   output logic [vcpi_pkg::MODE_W-1:0] video_mode,
   output vcpi_pkg::base_set_type     bases
);
   import vcpi_pkg::*;

   logic [BYTE_W-1:0] mode1_ff, mode1_in;
   logic [BYTE_W-1:0] mode2_ff, mode2_in;
   base_set_type      bases_ff, bases_in;
   logic [MODE_W-1:0] vm;
   logic [LATCH_W-1:0] lat;
   logic [ADDR_W-1:0]  pat_masked;

   assign vm  = decode_mode(mode1_ff, mode2_ff);
   assign lat = cmd.latch;
   assign pat_masked = {lat[2:0], 11'd0} & pattern_mask;

   // register write decode; mode seen is the one before this write
   always_comb begin
      mode1_in = mode1_ff;
      mode2_in = mode2_ff;
      bases_in = bases_ff;
      if (cmd.valid) begin
         case (cmd.index)
            REG_MODE1:   mode1_in = lat[BYTE_W-1:0];
            REG_MODE2:   mode2_in = lat[BYTE_W-1:0];
            REG_NAME:    bases_in.name = {lat[3:0], 10'd0} & name_mask & NAME_FIXED_MASK;
            REG_COLOR: begin
               if (vm == MODE_G2) begin
                  bases_in.color = {lat[7], 13'd0};
               end else begin
                  bases_in.color = {lat[7:0], 6'd0};
               end
            end
            REG_PATTERN: begin
               if (vm[1]) begin
                  bases_in.pattern = pat_masked & PATTERN_HALF_MASK;
               end else begin
                  bases_in.pattern = pat_masked;
               end
            end
            REG_SATTR:   bases_in.sprite_attr = {lat[6:1] & SATTR_MASK[6:1], 8'd0};
            REG_SPAT: begin
               if (vm[3]) begin
                  bases_in.sprite_pattern = {lat[2], 13'd0};
               end else begin
                  bases_in.sprite_pattern = {lat[2:0], 11'd0};
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode1_ff <= '0;
         mode2_ff <= '0;
         bases_ff <= '0;
      end else begin
         mode1_ff <= mode1_in;
         mode2_ff <= mode2_in;
         bases_ff <= bases_in;
      end
   end

   assign video_mode = vm;
   assign bases      = bases_ff;

endmodule

### src/video_chip_port_interface.sv
// ----------------------------------------------------------------------------
// video_chip_port_interface
// Host port sequencer: control latch, access address, read buffer and memories.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. Control writes that do not load the
// read buffer, data writes and the unused opcode have the response registered
// in the cycle after acceptance; data reads and a second control byte with
// the read code first wait in the fetch state for the registered read port
// of the video RAM. A new request is taken once the previous response is
// taken or is taken in the same cycle. Both memory depths must be powers of
// two; the access address is reduced to the low address bits. Memory that
// was never written reads back undefined data. There is no clearing pass.
`include "video_chip_port_interface_macros.svh"

module video_chip_port_interface #(
   parameter int VIDEO_MEM_DEPTH = 16384,
   parameter int COLOR_MEM_DEPTH = 32
) (
   input  logic   clock,
   input  logic   reset,
   vcpi_req_if.sink   req_bus,
   vcpi_rsp_if.source rsp_bus,
   vcpi_csr_if.sink   csr_bus
);
   import vcpi_pkg::*;

   localparam int VADDR_W = $clog2(VIDEO_MEM_DEPTH);
   localparam int CADDR_W = $clog2(COLOR_MEM_DEPTH);

   state_type          state_ff, state_in;
   logic               flag_ff, flag_in;
   logic [LATCH_W-1:0] latch_ff, latch_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [1:0]         code_ff, code_in;
   logic [BYTE_W-1:0]  rbuf_ff, rbuf_in;
   logic [ADDR_W-1:0]  name_mask_ff, name_mask_in;
   logic [ADDR_W-1:0]  pattern_mask_ff, pattern_mask_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]    read_data_ff, read_data_in;
   logic                 wr_valid_ff, wr_valid_in;
   logic [REG_IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [BYTE_W-1:0]    wr_val_ff, wr_val_in;
   logic                 undef_ff, undef_in;

   logic               req_fire;
   op_type             op;
   logic [LATCH_W-1:0] lat_new;
   logic               ctrl_pair;
   logic               fetch_req;
   logic [ADDR_W-1:0]  fetch_addr;
   logic               vram_en, vram_we;
   logic [VADDR_W-1:0] vram_addr;
   logic [BYTE_W-1:0]  vram_rdata;
   logic               cram_en;
   logic [BYTE_W-1:0]  cram_rdata;
   reg_cmd_type        reg_cmd;
   base_set_type       bases;
   logic [MODE_W-1:0]  video_mode;

   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign op            = op_type'(req_bus.opcode);
   assign csr_bus.ready = 1'b1;

   // control latch update and second-byte decode
   always_comb begin
      if (flag_ff) begin
         lat_new = (latch_ff & LATCH_LO_MASK) | {req_bus.data_byte, 8'd0};
      end else begin
         lat_new = (latch_ff & ~LATCH_LO_MASK) | {8'd0, req_bus.data_byte};
      end
   end

   assign ctrl_pair = (op == OP_CTRL) && flag_ff;
   assign fetch_req = (ctrl_pair && (code_type'(lat_new[15:14]) == CODE_VREAD)) ||
                      (op == OP_DREAD);
   assign fetch_addr = (op == OP_CTRL) ? (lat_new[ADDR_W-1:0] & ADDR_MASK) : addr_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_fire && fetch_req) state_in = ST_FETCH;
         ST_FETCH: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // memory strobes
   always_comb begin
      vram_en   = 1'b0;
      vram_we   = 1'b0;
      cram_en   = 1'b0;
      vram_addr = fetch_addr[VADDR_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && fetch_req) begin
               vram_en = 1'b1;
            end else if (req_fire && op == OP_DWRITE) begin
               vram_en = (code_type'(code_ff) != CODE_COLOR);
               vram_we = 1'b1;
               cram_en = (code_type'(code_ff) == CODE_COLOR);
            end
         end
         default: ;
      endcase
   end

   // port state update
   always_comb begin
      flag_in  = flag_ff;
      latch_in = latch_ff;
      addr_in  = addr_ff;
      code_in  = code_ff;
      rbuf_in  = rbuf_ff;
      reg_cmd  = '0;
      if (state_ff == ST_FETCH) begin
         rbuf_in = vram_rdata;
      end
      if (req_fire) begin
         case (op)
            OP_CTRL: begin
               flag_in  = !flag_ff;
               latch_in = lat_new;
               addr_in  = lat_new[ADDR_W-1:0] & ADDR_MASK;
               code_in  = lat_new[15:14];
               if (fetch_req) begin
                  addr_in = (lat_new[ADDR_W-1:0] + 14'd1) & ADDR_MASK;
               end
               reg_cmd.valid = ctrl_pair && (code_type'(lat_new[15:14]) == CODE_REG);
               reg_cmd.index = lat_new[11:8];
               reg_cmd.latch = lat_new;
            end
            OP_DWRITE: begin
               flag_in = 1'b0;
               addr_in = (addr_ff + 14'd1) & ADDR_MASK;
               rbuf_in = req_bus.data_byte;
            end
            OP_DREAD: begin
               flag_in = 1'b0;
               addr_in = (addr_ff + 14'd1) & ADDR_MASK;
            end
            default: ;
         endcase
      end
   end

   // response fields captured at acceptance
   always_comb begin
      read_data_in = read_data_ff;
      wr_valid_in  = wr_valid_ff;
      wr_idx_in    = wr_idx_ff;
      wr_val_in    = wr_val_ff;
      undef_in     = undef_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (req_fire) begin
         read_data_in = (op == OP_DREAD) ? rbuf_ff : '0;
         wr_valid_in  = reg_cmd.valid;
         wr_idx_in    = reg_cmd.valid ? REG_IDX_W'((lat_new & LATCH_HI_MASK) >> 8) : '0;
         wr_val_in    = reg_cmd.valid ? lat_new[BYTE_W-1:0] : '0;
         undef_in     = reg_cmd.valid && (lat_new[11:8] > REG_LAST_DEF);
         rsp_valid_in = !fetch_req;
      end
      if (state_ff == ST_FETCH) begin
         rsp_valid_in = 1'b1;
      end
   end

   // configuration writes
   always_comb begin
      name_mask_in    = name_mask_ff;
      pattern_mask_in = pattern_mask_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_NAME_MASK:    name_mask_in    = csr_bus.data & ADDR_MASK;
            CSR_PATTERN_MASK: pattern_mask_in = csr_bus.data & ADDR_MASK;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         flag_ff         <= 1'b0;
         latch_ff        <= '0;
         addr_ff         <= '0;
         code_ff         <= '0;
         rbuf_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         name_mask_ff    <= NAME_MASK_RESET;
         pattern_mask_ff <= PATTERN_MASK_RESET;
      end else begin
         state_ff        <= state_in;
         flag_ff         <= flag_in;
         latch_ff        <= latch_in;
         addr_ff         <= addr_in;
         code_ff         <= code_in;
         rbuf_ff         <= rbuf_in;
         rsp_valid_ff    <= rsp_valid_in;
         name_mask_ff    <= name_mask_in;
         pattern_mask_ff <= pattern_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      read_data_ff <= read_data_in;
      wr_valid_ff  <= wr_valid_in;
      wr_idx_ff    <= wr_idx_in;
      wr_val_ff    <= wr_val_in;
      undef_ff     <= undef_in;
   end

   vcpi_ram #(.WIDTH(BYTE_W), .DEPTH(VIDEO_MEM_DEPTH)) u_vram (
      .clock   (clock),
      .en      (vram_en),
      .we      (vram_we),
      .addr    (vram_addr),
      .wr_data (req_bus.data_byte),
      .rd_data (vram_rdata)
   );

   // colour memory is only written through this port
   vcpi_ram #(.WIDTH(BYTE_W), .DEPTH(COLOR_MEM_DEPTH)) u_cram (
      .clock   (clock),
      .en      (cram_en),
      .we      (1'b1),
      .addr    (addr_ff[CADDR_W-1:0]),
      .wr_data (req_bus.data_byte),
      .rd_data (cram_rdata)
   );

   vcpi_regs u_regs (
      .clock        (clock),
      .reset        (reset),
      .cmd          (reg_cmd),
      .name_mask    (name_mask_ff),
      .pattern_mask (pattern_mask_ff),
      .video_mode   (video_mode),
      .bases        (bases)
   );

   assign rsp_bus.valid               = rsp_valid_ff;
   assign rsp_bus.read_data           = read_data_ff;
   assign rsp_bus.video_mode          = video_mode;
   assign rsp_bus.name_base           = bases.name;
   assign rsp_bus.color_base          = bases.color;
   assign rsp_bus.pattern_base        = bases.pattern;
   assign rsp_bus.sprite_attr_base    = bases.sprite_attr;
   assign rsp_bus.sprite_pattern_base = bases.sprite_pattern;
   assign rsp_bus.reg_write_valid     = wr_valid_ff;
   assign rsp_bus.reg_write_index     = wr_idx_ff;
   assign rsp_bus.reg_write_value     = wr_val_ff;
   assign rsp_bus.undefined_reg       = undef_ff;

   // sequencer checks
   `VCPI_ASSERT_SAME(a_fetch_no_rsp, clock, reset, state_ff == ST_FETCH, !rsp_valid_ff)
   `VCPI_ASSERT_NEXT(a_fetch_entry, clock, reset, req_fire && fetch_req, state_ff == ST_FETCH)
   `VCPI_ASSERT_NEXT(a_fetch_done, clock, reset, state_ff == ST_FETCH,
                     state_ff == ST_IDLE && rsp_valid_ff)
   `VCPI_ASSERT_SAME(a_undef_valid, clock, reset, rsp_valid_ff && undef_ff, wr_valid_ff)
   `VCPI_ASSERT_SAME(a_no_wr_zero, clock, reset, rsp_valid_ff && !wr_valid_ff,
                     wr_idx_ff == '0 && wr_val_ff == '0)

endmodule
